// ===== design/kve_pkg.sv =====
// Shared types and constants of the Kalman velocity estimator.
`timescale 1ns / 1ps
package kve_pkg;

  // Multiplier operand and accumulator widths
  localparam int OP_W  = 33;
  localparam int ACC_W = 50;

  localparam logic signed [OP_W-1:0] FX_ONE     = 33'sd65536;
  localparam logic signed [OP_W-1:0] FX_NEG_ONE = -33'sd65536;
  localparam logic signed [31:0]     FX_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0]     FX_MIN     = 32'sh8000_0000;

  // Configuration register indexes
  localparam logic [1:0] REG_PROCESS_NOISE     = 2'd0;
  localparam logic [1:0] REG_MEASUREMENT_NOISE = 2'd1;

  // Sequencer phases, in execution order
  typedef enum logic [12:0] {
    PH_X0A  = 13'b0000000000001,
    PH_X0B  = 13'b0000000000010,
    PH_X1   = 13'b0000000000100,
    PH_PROW = 13'b0000000001000,
    PH_PCOL = 13'b0000000010000,
    PH_PQ   = 13'b0000000100000,
    PH_PS   = 13'b0000001000000,
    PH_ROW0 = 13'b0000010000000,
    PH_DIV  = 13'b0000100000000,
    PH_E    = 13'b0001000000000,
    PH_XC   = 13'b0010000000000,
    PH_PC   = 13'b0100000000000,
    PH_POS  = 13'b1000000000000
  } phase_t;

  // Steps of one element within a phase
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RDA  = 6'b000010,
    ST_RDB  = 6'b000100,
    ST_GO   = 6'b001000,
    ST_WAIT = 6'b010000,
    ST_WR   = 6'b100000
  } step_t;

endpackage

// ===== design/kve_mac.sv =====
// Pipelined multiply, round and accumulate unit with saturated result.
`timescale 1ns / 1ps
module kve_mac (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [kve_pkg::OP_W-1:0]  a,
  input  logic signed [kve_pkg::OP_W-1:0]  b,
  input  logic signed [kve_pkg::ACC_W-1:0] addend,
  output logic                             done,
  output logic signed [kve_pkg::ACC_W-1:0] sum,
  output logic signed [31:0]               res
);
  import kve_pkg::*;

  localparam int PW = 2 * OP_W;

  logic                    v1_r, v2_r, v3_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [ACC_W-1:0] add1_r, add2_r, rnd_r, sum_r;
  logic signed [PW-1:0]    biased;

  // round to nearest, ties away from zero
  assign biased = prod_r + (prod_r[PW-1] ? PW'(32767) : PW'(32768));

  // valid pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= a * b;
      add1_r <= addend;
    end
    if (v1_r) begin
      rnd_r  <= biased[ACC_W+15:16];
      add2_r <= add1_r;
    end
    if (v2_r) begin
      sum_r <= add2_r + rnd_r;
    end
  end

  assign done = v3_r;
  assign sum  = sum_r;

  // clamp to signed 32-bit range
  always_comb begin
    if (sum_r > ACC_W'(FX_MAX)) res = FX_MAX;
    else if (sum_r < ACC_W'(FX_MIN)) res = FX_MIN;
    else res = sum_r[31:0];
  end

endmodule

// ===== design/kve_div.sv =====
// Bit-serial Q16.16 divider, rounded to nearest and saturated.
`timescale 1ns / 1ps
module kve_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);
  import kve_pkg::*;

  localparam int NB = 48;
  localparam int CW = $clog2(NB + 1);

  logic              busy_r, done_r, neg_r, zero_r;
  logic [CW-1:0]     cnt_r;
  logic [NB-1:0]     dq_r;
  logic [32:0]       rem_r;
  logic [31:0]       md_r;
  logic signed [31:0] quo_r;
  logic [32:0]       mn, rem_sh;
  logic [31:0]       md;
  logic              ge;
  logic [31:0]       qlow;

  assign mn     = num[31] ? 33'(-{num[31], num}) : {1'b0, num};
  assign md     = den[31] ? 32'(-den) : den;
  assign rem_sh = {rem_r[31:0], dq_r[NB-1]};
  assign ge     = rem_sh >= {1'b0, md_r};
  assign qlow   = dq_r[31:0];

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CW'(NB)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r  <= num[31] ^ den[31];
      zero_r <= (den == '0);
      md_r   <= md;
      rem_r  <= '0;
      dq_r   <= NB'({mn, 16'b0}) + NB'(md >> 1);
    end else if (busy_r) begin
      if (cnt_r == CW'(NB)) begin
        if (zero_r) quo_r <= '0;
        else if (neg_r) quo_r <= (dq_r[NB-1:31] != '0) ? FX_MIN : $signed(-qlow);
        else quo_r <= (dq_r[NB-1:31] != '0) ? FX_MAX : $signed(qlow);
      end else begin
        rem_r <= ge ? (rem_sh - {1'b0, md_r}) : rem_sh;
        dq_r  <= {dq_r[NB-2:0], ge};
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== design/kalman_velocity_estimator.sv =====
// Top level: state memory, step sequencer and shared arithmetic units.
`timescale 1ns / 1ps
// One beat in gives one beat out after one full predict and correct step of
// the filter. State vector and covariance live in one memory and are handled
// one element at a time through one shared multiply-accumulate unit and a
// bit-serial divider for the gains; row 0 of the covariance is copied aside
// first. A new beat is accepted only after the last one is through, and also
// waits for any earlier result that is still held. Input is taken only while
// the sequencer is idle; a finished result waits in the output register while
// the next beat is accepted. Reset clears the state at once through per-entry
// valid bits.
module kalman_velocity_estimator #(
  parameter int STATES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // measurement[31:0], drive_u[63:32], time_step[79:64]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // velocity_estimate[31:0], position_estimate[63:32]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import kve_pkg::*;

  localparam int NW = STATES + STATES * STATES;
  localparam int AW = $clog2(NW);
  localparam int KW = $clog2(STATES);
  localparam logic [KW-1:0] K_LAST = KW'(STATES - 1);

  function automatic logic [AW-1:0] px(input logic [KW-1:0] i, input logic [KW-1:0] j);
    return AW'(STATES + int'(i) * STATES + int'(j));
  endfunction

  function automatic logic signed [OP_W-1:0] sx33(input logic [31:0] v);
    return $signed({v[31], v});
  endfunction

  function automatic logic signed [ACC_W-1:0] sx50(input logic [31:0] v);
    return $signed({{(ACC_W-32){v[31]}}, v});
  endfunction

  // registers
  step_t              st_r;
  phase_t             phase_r;
  logic [KW-1:0]      k_r, i_r;
  logic [31:0]        q_r, r_r;
  logic [31:0]        y_r, u_r;
  logic [15:0]        dt_r, hdt2_r;
  logic [31:0]        va_r, res_r, s_r, e_r, pos_r;
  logic [ACC_W-1:0]   tmp_r;
  logic [31:0]        gain_r [STATES];
  logic [31:0]        row0_r [STATES];
  logic [31:0]        mem_r [NW];
  logic [NW-1:0]      vld_r;
  logic [31:0]        rd_data_r;
  logic               out_tvalid_r;
  logic [31:0]        out_vel_r, out_pos_r;

  // decode
  logic [AW-1:0]             addr_a, addr_b, dst_addr, rd_addr;
  logic signed [OP_W-1:0]    mac_a, mac_b;
  logic signed [ACC_W-1:0]   mac_add;
  logic [31:0]               vb, g_sel;
  logic                      in_acc, mac_start, div_start, unit_done, last;
  logic                      mac_done, div_done;
  logic signed [ACC_W-1:0]   mac_sum;
  logic signed [31:0]        mac_res, div_quo;
  logic [31:0]               dt_sq;

  assign in_tready  = (st_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_pos_r, out_vel_r};
  assign vb         = rd_data_r;
  assign g_sel      = gain_r[(phase_r == PH_PC) ? i_r : k_r];
  assign rd_addr    = (st_r == ST_RDB) ? addr_b : addr_a;
  assign dt_sq      = in_tdata[79:64] * in_tdata[79:64];

  // per-phase operand and address selection
  always_comb begin
    addr_a   = AW'(1);
    addr_b   = AW'(0);
    dst_addr = AW'(0);
    mac_a    = $signed({17'b0, dt_r});
    mac_b    = sx33(va_r);
    mac_add  = sx50(va_r);
    unique case (phase_r)
      PH_X0A: begin
        addr_a  = AW'(1);
        addr_b  = AW'(0);
        mac_add = sx50(vb);
      end
      PH_X0B: begin
        mac_a    = $signed({17'b0, hdt2_r});
        mac_b    = sx33(u_r);
        mac_add  = tmp_r;
        dst_addr = AW'(0);
      end
      PH_X1: begin
        addr_a   = AW'(1);
        mac_b    = sx33(u_r);
        dst_addr = AW'(1);
      end
      PH_PROW: begin
        addr_a   = px(KW'(1), k_r);
        addr_b   = px('0, k_r);
        mac_add  = sx50(vb);
        dst_addr = px('0, k_r);
      end
      PH_PCOL: begin
        addr_a   = px(k_r, KW'(1));
        addr_b   = px(k_r, '0);
        mac_add  = sx50(vb);
        dst_addr = px(k_r, '0);
      end
      PH_PQ: begin
        addr_a   = px(KW'(1), KW'(1));
        mac_a    = $signed({1'b0, q_r});
        mac_b    = FX_ONE;
        dst_addr = px(KW'(1), KW'(1));
      end
      PH_PS: begin
        addr_a = px('0, '0);
        mac_a  = $signed({1'b0, r_r});
        mac_b  = FX_ONE;
      end
      PH_ROW0: addr_a = px('0, k_r);
      PH_DIV:  addr_a = px(k_r, '0);
      PH_E: begin
        addr_a  = AW'(0);
        mac_a   = sx33(va_r);
        mac_b   = FX_NEG_ONE;
        mac_add = sx50(y_r);
      end
      PH_XC: begin
        addr_a   = AW'(k_r);
        mac_a    = sx33(g_sel);
        mac_b    = sx33(e_r);
        dst_addr = AW'(k_r);
      end
      PH_PC: begin
        addr_a   = px(i_r, k_r);
        mac_a    = -sx33(g_sel);
        mac_b    = sx33(row0_r[k_r]);
        dst_addr = px(i_r, k_r);
      end
      PH_POS: begin
        addr_a  = AW'(1);
        mac_a   = sx33(va_r);
        mac_b   = $signed({17'b0, dt_r});
        mac_add = sx50(pos_r);
      end
      default: ;
    endcase
  end

  assign mac_start = (st_r == ST_GO) && (phase_r != PH_DIV) && (phase_r != PH_ROW0);
  assign div_start = (st_r == ST_GO) && (phase_r == PH_DIV);
  assign unit_done = (phase_r == PH_DIV) ? div_done : mac_done;

  always_comb begin
    unique case (phase_r)
      PH_PROW, PH_PCOL, PH_ROW0, PH_DIV, PH_XC: last = (k_r == K_LAST);
      PH_PC:   last = (k_r == K_LAST) && (i_r == K_LAST);
      default: last = 1'b1;
    endcase
  end

  kve_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mac_start),
    .a      (mac_a),
    .b      (mac_b),
    .addend (mac_add),
    .done   (mac_done),
    .sum    (mac_sum),
    .res    (mac_res)
  );

  kve_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (va_r),
    .den   (s_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= 32'd65536;
      r_r <= 32'd3277;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PROCESS_NOISE:     q_r <= cfg_data;
        REG_MEASUREMENT_NOISE: r_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // state memory, unwritten entries read as zero
  always_ff @(posedge clk) begin
    rd_data_r <= vld_r[rd_addr] ? mem_r[rd_addr] : '0;
    if (st_r == ST_WR && (phase_r == PH_X0B || phase_r == PH_X1 || phase_r == PH_PROW ||
        phase_r == PH_PCOL || phase_r == PH_PQ || phase_r == PH_XC || phase_r == PH_PC)) begin
      mem_r[dst_addr] <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (st_r == ST_WR && (phase_r == PH_X0B || phase_r == PH_X1 ||
        phase_r == PH_PROW || phase_r == PH_PCOL || phase_r == PH_PQ ||
        phase_r == PH_XC || phase_r == PH_PC)) begin
      vld_r[dst_addr] <= 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      phase_r      <= PH_X0A;
      k_r          <= '0;
      i_r          <= '0;
      pos_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // result beat taken and no new one loaded this cycle
      if (out_tvalid_r && out_tready && !(st_r == ST_WR && phase_r == PH_POS)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (in_acc) begin
            y_r     <= in_tdata[31:0];
            u_r     <= in_tdata[63:32];
            dt_r    <= in_tdata[79:64];
            hdt2_r  <= 16'((33'(dt_sq) + 33'd65536) >> 17);
            phase_r <= PH_X0A;
            k_r     <= '0;
            i_r     <= '0;
            st_r    <= ST_RDA;
          end
        end
        ST_RDA: st_r <= ST_RDB;
        ST_RDB: begin
          va_r <= rd_data_r;
          st_r <= ST_GO;
        end
        ST_GO: st_r <= (phase_r == PH_ROW0) ? ST_WR : ST_WAIT;
        ST_WAIT: begin
          if (unit_done) begin
            res_r <= (phase_r == PH_DIV) ? div_quo : mac_res;
            tmp_r <= mac_sum;
            st_r  <= ST_WR;
          end
        end
        ST_WR: begin
          if (!(phase_r == PH_POS && out_tvalid_r && !out_tready)) begin
            case (phase_r)
              PH_PS:   s_r <= res_r;
              PH_ROW0: row0_r[k_r] <= va_r;
              PH_DIV:  gain_r[k_r] <= res_r;
              PH_E:    e_r <= res_r;
              PH_POS: begin
                pos_r        <= res_r;
                out_vel_r    <= va_r;
                out_pos_r    <= res_r;
                out_tvalid_r <= 1'b1;
              end
              default: ;
            endcase
            if (!last) begin
              st_r <= ST_RDA;
              if (phase_r == PH_PC && k_r == K_LAST) begin
                k_r <= '0;
                i_r <= i_r + 1'b1;
              end else begin
                k_r <= k_r + 1'b1;
              end
            end else begin
              k_r  <= '0;
              i_r  <= '0;
              st_r <= ST_RDA;
              unique case (phase_r)
                PH_X0A:  phase_r <= PH_X0B;
                PH_X0B:  phase_r <= PH_X1;
                PH_X1:   phase_r <= PH_PROW;
                PH_PROW: phase_r <= PH_PCOL;
                PH_PCOL: phase_r <= PH_PQ;
                PH_PQ:   phase_r <= PH_PS;
                PH_PS:   phase_r <= PH_ROW0;
                PH_ROW0: phase_r <= PH_DIV;
                PH_DIV:  phase_r <= PH_E;
                PH_E:    phase_r <= PH_XC;
                PH_XC:   phase_r <= PH_PC;
                PH_PC:   phase_r <= PH_POS;
                PH_POS: begin
                  phase_r <= PH_X0A;
                  st_r    <= ST_IDLE;
                end
                default: phase_r <= PH_X0A;
              endcase
            end
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready) else $error("input taken while busy");

  a_mac_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> (st_r == ST_WAIT)) else $error("mac result outside wait step");

  a_result_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_WR && phase_r == PH_POS && out_tvalid_r && !out_tready)
    |=> (st_r == ST_WR)) else $error("result overwritten while stalled");

endmodule

// ===== bench/tb_kalman_velocity_estimator.sv =====
// Self-checking bench for the Kalman velocity estimator: streams items, predicts results.
`timescale 1ns / 1ps
module tb_kalman_velocity_estimator;
  import kve_pkg::*;

  localparam int NST = 4;
  localparam int RANDOM_ITEMS = 1430;

  // indexes past the two mapped registers
  localparam logic [1:0] REG_UNMAPPED_LO = 2'd2;
  localparam logic [1:0] REG_UNMAPPED_HI = 2'd3;

  typedef struct packed {
    logic [15:0]        dt;
    logic signed [31:0] u;
    logic signed [31:0] y;
  } meas_beat_t;

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
  } est_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;   // measurement, drive_u, time_step
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // velocity_estimate, position_estimate
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  kalman_velocity_estimator #(.STATES(NST)) u_dut (.*);

  // Filter state mirror
  logic [31:0] q_noise, r_noise;
  longint      xs[NST];
  longint      pcov[NST][NST];
  longint      pos_acc;

  meas_beat_t  pending_meas[$];
  est_beat_t   expected_est[$];
  int          errors;
  int          send_idle_pct, recv_idle_pct;
  bit          hold_send;
  int          n_sent, n_checked;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q16.16 product, nearest with ties away from zero
  function automatic longint qmul(longint a, longint b);
    longint unsigned ma, mb, m;
    bit neg;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    m = (ma * mb + 64'd32768) >> 16;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint qdiv(longint n, longint d);
    longint unsigned mn, md, q;
    bit neg;
    if (d == 0) return 0;
    neg = (n < 0) != (d < 0);
    mn = ((n < 0) ? -n : n) << 16;
    md = (d < 0) ? -d : d;
    q = (mn + md / 2) / md;
    if (q > 64'd4294967296) q = 64'd4294967296;
    return clamp32(neg ? -longint'(q) : longint'(q));
  endfunction

  // One predict and correct cycle; returns the expected estimate beat
  function automatic est_beat_t filter_step(meas_beat_t m);
    longint dt, hdt2, s, e;
    longint gain[NST];
    longint row0[NST];
    est_beat_t r;
    dt = m.dt;
    hdt2 = (dt * dt + 65536) >>> 17;
    xs[0] = clamp32(xs[0] + qmul(dt, xs[1]) + qmul(hdt2, m.u));
    xs[1] = clamp32(xs[1] + qmul(dt, m.u));
    for (int j = 0; j < NST; j++) pcov[0][j] = clamp32(pcov[0][j] + qmul(dt, pcov[1][j]));
    for (int i = 0; i < NST; i++) pcov[i][0] = clamp32(pcov[i][0] + qmul(dt, pcov[i][1]));
    pcov[1][1] = clamp32(pcov[1][1] + longint'(q_noise));
    s = clamp32(pcov[0][0] + longint'(r_noise));
    for (int i = 0; i < NST; i++) gain[i] = qdiv(pcov[i][0], s);
    e = clamp32(longint'(m.y) - xs[0]);
    for (int i = 0; i < NST; i++) xs[i] = clamp32(xs[i] + qmul(gain[i], e));
    for (int j = 0; j < NST; j++) row0[j] = pcov[0][j];
    for (int i = 0; i < NST; i++)
      for (int j = 0; j < NST; j++)
        pcov[i][j] = clamp32(pcov[i][j] - qmul(gain[i], row0[j]));
    pos_acc = clamp32(pos_acc + qmul(xs[1], dt));
    r.vel = xs[1][31:0];
    r.pos = pos_acc[31:0];
    return r;
  endfunction

  // Driver: one item per beat from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_tready) begin
      // hold the beat until taken
    end else if (pending_meas.size() > 0 && !hold_send &&
                 $urandom_range(99) >= send_idle_pct) begin
      in_tdata  <= pending_meas.pop_front();
      in_tvalid <= 1'b1;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Predict on acceptance
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      expected_est.push_back(filter_step(meas_beat_t'(in_tdata)));
      n_sent++;
    end
  end

  // Monitor and receiver stall
  always @(posedge clk) begin
    est_beat_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        n_checked++;
        if (expected_est.size() == 0) begin
          $error("unexpected estimate beat %h", out_tdata);
          errors++;
        end else begin
          want = expected_est.pop_front();
          if (got.vel !== want.vel) begin
            $error("velocity_estimate: expected %0d, got %0d", want.vel, got.vel);
            errors++;
          end
          if (got.pos !== want.pos) begin
            $error("position_estimate: expected %0d, got %0d", want.pos, got.pos);
            errors++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic add_meas(logic [31:0] y, logic [31:0] u, logic [15:0] dt);
    meas_beat_t m;
    m.y = y;
    m.u = u;
    m.dt = dt;
    pending_meas.push_back(m);
  endtask

  task automatic drain();
    while (pending_meas.size() > 0 || in_tvalid || expected_est.size() > 0)
      @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // Register write; only issued while drained
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_PROCESS_NOISE) q_noise = val;
    else if (idx == REG_MEASUREMENT_NOISE) r_noise = val;
    @(posedge clk);
  endtask

  task automatic add_random(int n);
    logic [31:0] y, u;
    logic [15:0] dt;
    for (int k = 0; k < n; k++) begin
      y = $urandom;
      u = $urandom;
      dt = 16'($urandom);
      // mostly modest motion so the filter tracks rather than saturating
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          y = $signed($urandom_range(2000000)) - 1000000;
          u = $signed($urandom_range(200000)) - 100000;
          dt = 16'($urandom_range(3000));
        end
        5, 6: dt = 16'($urandom_range(65535));
        default: ;
      endcase
      add_meas(y, u, dt);
    end
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    out_tready = 0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    hold_send = 0;
    send_idle_pct = 28;
    recv_idle_pct = 53;
    q_noise = 32'd65536;
    r_noise = 32'd3277;
    pos_acc = 0;
    foreach (xs[i]) xs[i] = 0;
    foreach (pcov[i, j]) pcov[i][j] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes at reset noise settings
    add_meas(32'h0000_0000, 32'h0000_0000, 16'h0000);
    add_meas(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
    add_meas(32'h8000_0000, 32'h8000_0000, 16'hFFFF);
    add_meas(32'h0001_0000, 32'hFFFF_0000, 16'h0001);
    add_meas(32'hFFFF_FFFF, 32'h0000_0001, 16'h8000);
    add_meas(32'h7FFF_FFFF, 32'h8000_0000, 16'h0000);
    drain();

    // Sender holds off while two items queue up, then sends them
    hold_send = 1;
    add_meas(32'h0002_0000, 32'h0000_8000, 16'h0100);
    add_meas(32'hFFFE_0000, 32'hFFFF_8000, 16'h0100);
    repeat (20) @(posedge clk);
    hold_send = 0;
    drain();

    // Zero measurement noise: zero innovation variance when P[0][0] is zero
    write_reg(REG_MEASUREMENT_NOISE, 32'h0000_0000);
    write_reg(REG_PROCESS_NOISE, 32'h0000_0000);
    add_meas(32'h0001_0000, 32'h0000_0000, 16'h0000);
    add_meas(32'h0003_0000, 32'h0001_0000, 16'h0400);
    drain();
    write_reg(REG_PROCESS_NOISE, 32'hFFFF_FFFF);
    write_reg(REG_MEASUREMENT_NOISE, 32'hFFFF_FFFF);
    write_reg(REG_UNMAPPED_LO, 32'h1234_5678);  // unmapped index, ignored
    write_reg(REG_UNMAPPED_HI, 32'h0000_0001);
    add_meas(32'h0100_0000, 32'hFF00_0000, 16'hFFFF);
    add_meas(32'h8000_0000, 32'h7FFF_FFFF, 16'h1000);
    drain();

    // Random phases with different noise settings and idling
    write_reg(REG_PROCESS_NOISE, 32'd65536);
    write_reg(REG_MEASUREMENT_NOISE, 32'd1);
    add_random(RANDOM_ITEMS / 3);
    drain();
    send_idle_pct = 53;
    recv_idle_pct = 28;
    write_reg(REG_PROCESS_NOISE, $urandom);
    write_reg(REG_MEASUREMENT_NOISE, $urandom | 32'd1);
    add_random(RANDOM_ITEMS / 3);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_PROCESS_NOISE, 32'd655);
    write_reg(REG_MEASUREMENT_NOISE, 32'd3277);
    add_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    drain();

    foreach (expected_est[k]) begin
      $error("estimate never arrived: vel %0d pos %0d",
             expected_est[k].vel, expected_est[k].pos);
      errors++;
    end
    $display("Sent %0d measurement beats, checked %0d estimates across six noise settings,",
             n_sent, n_checked);
    $display("with directed extremes, zero noise and three idling profiles.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
